[sv/assert_macros.svh]
// Assertion macros used by the checker file anb_checker.sv.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ANB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ANB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/anb_pkg.sv]
// Shared types and constants of the Annex-B NAL splitter.
// No dependencies; imported by anb_fifo, anb_core, the top level and the testbench.
package anb_pkg;

  // Most result bytes that one input byte can release.
  localparam int ANB_MAX_RES    = 5;
  localparam int ANB_RES_CNT_W  = $clog2(ANB_MAX_RES + 1);
  // Default depth of the result queue (power of two, at least 8).
  localparam int ANB_FIFO_DEPTH = 8;

  // Final byte of a start code.
  localparam logic [7:0] ANB_SC_BYTE = 8'h01;

  typedef struct packed {
    logic [7:0] nal_byte;
    logic       nal_first;
    logic       nal_last;
  } anb_res_t;

endpackage

[sv/anb_fifo.sv]
// Result queue of the Annex-B NAL splitter: takes up to ANB_MAX_RES results per
// cycle and hands out one per transfer. Depends on anb_pkg.
module anb_fifo
  import anb_pkg::*;
#(
  parameter int DEPTH = ANB_FIFO_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  anb_res_t [ANB_MAX_RES-1:0]          push_res,
  input  logic [ANB_RES_CNT_W-1:0]            push_cnt,
  output logic                                space_ok,
  output logic                                head_valid,
  input  logic                                head_stall,
  output anb_res_t                            head
);

  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int LIMIT = DEPTH - ANB_MAX_RES;

  anb_res_t          mem_r [DEPTH];
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              pop;

  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign pop        = head_valid && !head_stall;
  // Room is judged on the registered fill level, so a full burst always fits.
  assign space_ok   = (cnt_r <= CW'(LIMIT));

  assign rd_ptr_nxt = rd_ptr_r + PW'(pop);
  assign wr_ptr_nxt = wr_ptr_r + PW'(push_cnt);
  assign cnt_nxt    = cnt_r + CW'(push_cnt) - CW'(pop);

  always_ff @(posedge clk) begin
    for (int k = 0; k < ANB_MAX_RES; k++) begin
      if (ANB_RES_CNT_W'(k) < push_cnt) begin
        mem_r[wr_ptr_r + PW'(k)] <= push_res[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[sv/anb_core.sv]
// Start code scanner of the Annex-B NAL splitter: holds the pending bytes and
// works out the results that each accepted byte releases. Depends on anb_pkg.
module anb_core
  import anb_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_take,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_stream_end,
  output anb_res_t [ANB_MAX_RES-1:0]  res,
  output logic [ANB_RES_CNT_W-1:0]    res_cnt
);

  typedef struct packed {
    logic [3:0][7:0] pend;
    logic [2:0]      cnt;
    logic            in_nal;
    logic            started;
  } anb_state_t;

  typedef struct packed {
    anb_state_t                  st;
    anb_res_t [ANB_MAX_RES-1:0]  res;
    logic [ANB_RES_CNT_W-1:0]    n;
  } anb_work_t;

  anb_state_t state_r, state_nxt;
  anb_work_t  w;
  logic [2:0] tz;
  logic [2:0] keep;

  function automatic anb_work_t put_res(anb_work_t wi, logic [7:0] b, logic last);
    anb_work_t r;
    r = wi;
    r.res[wi.n].nal_byte  = b;
    r.res[wi.n].nal_first = !wi.st.started;
    r.res[wi.n].nal_last  = last;
    r.st.started = 1'b1;
    r.n = wi.n + ANB_RES_CNT_W'(1);
    return r;
  endfunction

  function automatic anb_work_t emit_front(anb_work_t wi);
    anb_work_t r;
    r = put_res(wi, wi.st.pend[0], 1'b0);
    r.st.pend = {8'h00, wi.st.pend[3:1]};
    r.st.cnt  = wi.st.cnt - 3'd1;
    return r;
  endfunction

  function automatic anb_work_t flush_all(anb_work_t wi);
    anb_work_t r;
    r = wi;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < wi.st.cnt) begin
        r = put_res(r, wi.st.pend[i], (3'(i + 1) == wi.st.cnt));
      end
    end
    r.st.cnt = 3'd0;
    return r;
  endfunction

  // Number of zero bytes at the young end of the held bytes.
  function automatic logic [2:0] trailing(logic [3:0][7:0] pend, logic [2:0] cnt);
    logic [2:0] z;
    logic [2:0] pos;
    logic       run;
    z   = 3'd0;
    run = 1'b1;
    for (int k = 0; k < 4; k++) begin
      pos = cnt - 3'(k) - 3'd1;
      if (run && (3'(k) < cnt) && (pend[pos[1:0]] == 8'h00)) begin
        z = z + 3'd1;
      end else begin
        run = 1'b0;
      end
    end
    return z;
  endfunction

  always_comb begin
    w      = '0;
    w.st   = state_r;
    tz     = trailing(w.st.pend, w.st.cnt);
    keep   = 3'd1;
    if (!w.st.in_nal) begin
      // Outside a unit the count tracks the run of zeros, saturated at three.
      if ((in_data_byte == ANB_SC_BYTE) && (w.st.cnt >= 3'd2)) begin
        w.st.in_nal  = 1'b1;
        w.st.started = 1'b0;
        w.st.cnt     = 3'd0;
      end else if (in_data_byte == 8'h00) begin
        w.st.cnt = (w.st.cnt < 3'd3) ? (w.st.cnt + 3'd1) : 3'd3;
      end else begin
        w.st.cnt = 3'd0;
      end
    end else if ((in_data_byte == ANB_SC_BYTE) && (tz >= 3'd2)) begin
      // A start code ends the unit; three zeros form the four-byte code.
      w.st.cnt     = w.st.cnt - ((tz >= 3'd3) ? 3'd3 : 3'd2);
      w            = flush_all(w);
      w.st.started = 1'b0;
    end else begin
      if (w.st.cnt >= 3'd4) begin
        w = emit_front(w);
      end
      w.st.pend[w.st.cnt[1:0]] = in_data_byte;
      w.st.cnt = w.st.cnt + 3'd1;
      tz   = trailing(w.st.pend, w.st.cnt);
      keep = ((tz > 3'd3) ? 3'd3 : tz) + 3'd1;
      // Hold the trailing zeros that may still open a start code plus the byte before them.
      for (int j = 0; j < 4; j++) begin
        if (w.st.cnt > keep) begin
          w = emit_front(w);
        end
      end
    end
    if (in_stream_end) begin
      if (w.st.in_nal) begin
        w = flush_all(w);
      end
      w.st = '0;
    end
  end

  assign state_nxt = w.st;
  assign res       = w.res;
  assign res_cnt   = in_take ? w.n : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_take) begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/annexb_nal_splitter.sv]
// Top level of the Annex-B NAL splitter.
// Depends on anb_pkg, anb_core and anb_fifo.
//
// The input channel (in_valid, in_stall, in_data_byte, in_stream_end) takes one
// byte of an Annex-B stream per transfer. The result channel (out_valid,
// out_stall, out_nal_byte, out_nal_first, out_nal_last) gives the payload
// bytes of each NAL unit, one per transfer, with first and last marks.
// Start codes and bytes before the first start code are dropped. Setting
// in_stream_end on a byte closes the open unit after that byte.
// One input byte per cycle is sustained while in_stall is low. Each byte is
// decoded in the cycle it is transferred and its results enter the result
// queue at that clock edge, so a released byte can leave in the next cycle.
// A payload byte is held back until a later byte, a start code or the stream
// end decides its last mark, which can delay it by up to four input bytes.
// One transfer may release up to five results; in_stall rises while the queue
// holds more than FIFO_DEPTH minus five results, so a stalled receiver backs
// up into the input once the queue has filled that far, and a burst of
// results can stall the input even when the receiver keeps up.
// rst_n is synchronous and active low; it empties the queue and returns the
// scanner to searching for the first start code.
module annexb_nal_splitter
  import anb_pkg::*;
#(
  parameter int FIFO_DEPTH = ANB_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_stream_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_nal_byte,
  output logic       out_nal_first,
  output logic       out_nal_last
);

  anb_res_t [ANB_MAX_RES-1:0]  res;
  logic [ANB_RES_CNT_W-1:0]    res_cnt;
  logic                        space_ok;
  logic                        in_take;
  anb_res_t                    head;

  assign in_stall = !space_ok;
  assign in_take  = in_valid && space_ok;

  anb_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_take      (in_take),
    .in_data_byte (in_data_byte),
    .in_stream_end(in_stream_end),
    .res          (res),
    .res_cnt      (res_cnt)
  );

  anb_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_res  (res),
    .push_cnt  (res_cnt),
    .space_ok  (space_ok),
    .head_valid(out_valid),
    .head_stall(out_stall),
    .head      (head)
  );

  assign out_nal_byte  = head.nal_byte;
  assign out_nal_first = head.nal_first;
  assign out_nal_last  = head.nal_last;

endmodule

[sv/anb_checker.sv]
// Port-level checks of the Annex-B NAL splitter, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module anb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_nal_byte,
  input logic       out_nal_first,
  input logic       out_nal_last
);

  logic       out_xfer;
  logic       out_stalled;
  logic [9:0] out_bus;
  logic       exp_first_r;

  assign out_xfer    = out_valid && !out_stall;
  assign out_stalled = out_valid && out_stall;
  assign out_bus     = {out_nal_byte, out_nal_first, out_nal_last};

  // Every unit starts right after the last byte of the one before.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_first_r <= 1'b1;
    end else if (out_xfer) begin
      exp_first_r <= out_nal_last;
    end
  end

  `ANB_ASSERT_NOW(a_first_seq, out_xfer, out_nal_first == exp_first_r, "first mark out of order")
  `ANB_ASSERT_NOW(a_stall_needs_backlog, in_stall, out_valid, "stall with empty queue")
  `ANB_ASSERT_NOW(a_idle_after_reset, $past(!rst_n), !in_stall && !out_valid, "busy after reset")
  `ANB_ASSERT_NEXT(a_out_hold, out_stalled, out_valid && $stable(out_bus), "stalled result changed")

endmodule

bind annexb_nal_splitter anb_checker u_anb_checker (.*);

[tb/tb_annexb_nal_splitter.sv]
// Self-checking testbench for the Annex-B NAL splitter (annexb_nal_splitter).
// Depends on anb_pkg and the RTL of the block. A scoreboard class predicts the
// payload bytes with their first and last marks and checks every result transfer.
module tb_annexb_nal_splitter;
  import anb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 290;
  localparam int DRAIN_CYCLES = 20;

  class nal_unit_predictor;
    logic [7:0] held [4];
    int         held_cnt;
    bit         in_unit;
    bit         unit_open;
    anb_res_t   awaited [$];
    int         fails;

    function new();
      clear();
      fails = 0;
    endfunction

    function void clear();
      foreach (held[i]) held[i] = 8'h00;
      held_cnt  = 0;
      in_unit   = 0;
      unit_open = 0;
    endfunction

    function void emit(logic [7:0] b, bit last);
      anb_res_t r;
      r.nal_byte  = b;
      r.nal_first = !unit_open;
      r.nal_last  = last;
      awaited.insert(awaited.size(), r);
      unit_open = 1;
    endfunction

    function void release_oldest();
      emit(held[0], 1'b0);
      for (int i = 1; i < 4; i++) held[i-1] = held[i];
      held[3] = 8'h00;
      held_cnt--;
    endfunction

    function void flush_held();
      int c;
      c = (held_cnt > 4) ? 4 : held_cnt;
      for (int i = 0; i < c; i++) emit(held[i], i + 1 == c);
      held_cnt = 0;
    endfunction

    function int zero_tail();
      int z;
      int c;
      z = 0;
      c = (held_cnt > 4) ? 4 : held_cnt;
      while (z < c && held[c-1-z] == 8'h00) z++;
      return z;
    endfunction

    // Called once per accepted input transfer.
    function void predict_byte(logic [7:0] b, logic eos);
      int tz;
      int keep;
      if (!in_unit) begin
        // Outside a unit the count tracks the current run of zeros.
        if (b == ANB_SC_BYTE && held_cnt >= 2) begin
          in_unit   = 1;
          unit_open = 0;
          held_cnt  = 0;
        end else if (b == 8'h00) begin
          held_cnt = (held_cnt < 3) ? held_cnt + 1 : 3;
        end else begin
          held_cnt = 0;
        end
      end else begin
        tz = zero_tail();
        if (b == ANB_SC_BYTE && tz >= 2) begin
          // At most one extra zero joins the start code; the rest are payload.
          held_cnt -= (tz >= 3) ? 3 : 2;
          flush_held();
          unit_open = 0;
        end else begin
          if (held_cnt >= 4) release_oldest();
          held[held_cnt] = b;
          held_cnt++;
          tz   = zero_tail();
          keep = ((tz > 3) ? 3 : tz) + 1;
          while (held_cnt > keep) release_oldest();
        end
      end
      if (eos) begin
        if (in_unit) flush_held();
        clear();
      end
    endfunction

    function void check_payload(logic [7:0] b, logic first, logic last);
      anb_res_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result transfer: nal_byte %02h first %0b last %0b",
               b, first, last);
        fails++;
        return;
      end
      want = awaited.pop_front();
      if (want.nal_byte !== b) begin
        $error("nal_byte: expected %02h, actual %02h", want.nal_byte, b);
        fails++;
      end
      if (want.nal_first !== first) begin
        $error("nal_first: expected %0b, actual %0b", want.nal_first, first);
        fails++;
      end
      if (want.nal_last !== last) begin
        $error("nal_last: expected %0b, actual %0b", want.nal_last, last);
        fails++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_stream_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_nal_byte;
  logic       out_nal_first;
  logic       out_nal_last;

  nal_unit_predictor pred = new();
  int burst_left = 0;
  int sent = 0;

  annexb_nal_splitter DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_stream_end(in_stream_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_nal_byte (out_nal_byte),
    .out_nal_first(out_nal_first),
    .out_nal_last (out_nal_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Sender: bursts of random length separated by random gaps.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_stream_end <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred.predict_byte(b, eos);
    sent++;
  endtask

  // Zeros and start code bytes are common so that codes form inside payloads.
  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'h00;
      4:          return ANB_SC_BYTE;
      5:          return 8'h03;
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_start_code(input int zeros);
    repeat (zeros) send_byte(8'h00, 1'b0);
    send_byte(ANB_SC_BYTE, 1'b0);
  endtask

  // Receiver: the stall pattern is drawn anew from four modes at intervals counted by stall_tick.
  int stall_tick = 0;
  int stall_mode = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      pred.check_payload(out_nal_byte, out_nal_first, out_nal_last);
    if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
    stall_tick++;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_tick % 5 < 2);
    endcase
  end

  // Watchdog: ends the run when no transfer happens for too long.
  initial begin
    int idle;
    idle = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Each entry holds the stream end flag above the data byte.
  logic [8:0] directed [] = '{
    9'h0FF, 9'h001,                                     // garbage before any code
    9'h000, 9'h000, 9'h000, 9'h001,                     // four-byte start code
    9'h080, 9'h07F, 9'h000, 9'h000, 9'h000, 9'h000, 9'h001, // long zero run
    9'h000, 9'h000, 9'h001,                             // empty unit
    9'h0AA, 9'h000, 9'h100,                             // end keeps trailing zeros
    9'h134,                                             // end outside any unit
    9'h000, 9'h000, 9'h001, 9'h05A, 9'h000, 9'h000, 9'h101 // end completes a code
  };

  initial begin
    int kind;
    int len;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);

    while (sent < directed.size() + RANDOM_ITEMS) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        len = $urandom_range(1, 5);
        repeat (len) send_byte(payload_byte(), 1'b0);
      end else if (kind == 1) begin
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        send_start_code($urandom_range(0, 3) == 0 ? $urandom_range(3, 4) : 2);
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14);
        for (int i = 0; i < len; i++)
          send_byte(payload_byte(), (i == len - 1) && ($urandom_range(0, 7) == 0));
      end
    end
    send_byte(payload_byte(), 1'b1);
    in_valid <= 1'b0;

    while (pred.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pred.fails == 0 && pred.awaited.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[annexb_nal_splitter.f]
+incdir+sv
sv/anb_pkg.sv
sv/anb_fifo.sv
sv/anb_core.sv
sv/annexb_nal_splitter.sv
sv/anb_checker.sv
tb/tb_annexb_nal_splitter.sv
